// File: hdl/pssr_pkg.sv
`timescale 1ns / 1ps

package pssr_pkg;

    localparam int TIME_WIDTH_DEF     = 32;
    localparam int TEMP_FRAC_BITS_DEF = 4;

    localparam int TEMP_W    = 16;
    localparam int GAIN_W    = 8;
    localparam int PERIOD_W  = 16;
    localparam int POWER_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_POWER = 100;

    // period / 100 as a reciprocal multiply, exact for any 16 bit period
    localparam int DIV100_MAGIC = 83887;
    localparam int DIV100_SHIFT = 23;
    localparam int QUOT_W       = 10;

    // shared bit-serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MCAND_W  = 18;
    localparam int MPLIER_W = 8;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int MCNT_W   = $clog2(MPLIER_W + 1);

    localparam logic [GAIN_W-1:0]   GAIN_RST     = 8'd1;
    localparam logic [TEMP_W-1:0]   SETPOINT_RST = 16'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN           = 3'd0,
        CFG_SUSTAIN_BIAS   = 3'd1,
        CFG_SETPOINT       = 3'd2,
        CFG_CHANNEL_ENABLE = 3'd3,
        CFG_INPUT_ENABLE   = 3'd4,
        CFG_PERIOD_MS      = 3'd5,
        CFG_MIN_POWER      = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_POWER,
        ST_MUL_TIME,
        ST_UPDATE
    } pssr_state_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0]        mplier;
    } mul_req_t;

endpackage

// File: hdl/pssr_serial_mul.sv
`timescale 1ns / 1ps

module pssr_serial_mul import pssr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mul_req_t                  req,
    output logic                      busy,
    output logic signed [PROD_W-1:0]  product
);

    localparam int HI_W  = MCAND_W + 1;
    localparam int ACC_W = HI_W + MPLIER_W;

    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [MCNT_W-1:0]        count_reg, count_next;
    logic [MCAND_W-1:0]       mcand_reg, mcand_next;
    logic [HI_W-1:0]          addend;
    logic [HI_W-1:0]          sum;

    // one multiplier bit per cycle, lsb first, partial sum shifted right
    always_comb
    begin
        addend     = acc_reg[0] ? {mcand_reg[MCAND_W-1], mcand_reg} : '0;
        sum        = acc_reg[ACC_W-1:MPLIER_W] + addend;
        acc_next   = acc_reg;
        count_next = count_reg;
        mcand_next = mcand_reg;
        if (req.start)
        begin
            acc_next   = {{HI_W{1'b0}}, req.mplier};
            count_next = MCNT_W'(MPLIER_W);
            mcand_next = req.mcand;
        end
        else if (count_reg != '0)
        begin
            acc_next   = {sum[HI_W-1], sum, acc_reg[MPLIER_W-1:1]};
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = (count_reg != '0);
    assign product = acc_reg[PROD_W-1:0];

endmodule

// File: hdl/proportional_ssr_time_driver.sv
`timescale 1ns / 1ps
// flow: a beat is taken in ST_IDLE and passes ST_MUL_GAIN, ST_POWER, ST_MUL_TIME and ST_UPDATE;
// no new beat is taken until ST_UPDATE hands its result to a free output; the states run two 8-step
// bit-serial multiplies (error times gain, then period/100 times power) on one shared multiplier
// reset: asynchronous, all timing state, permit and relay drive cleared,
// configuration registers return to their default values

module proportional_ssr_time_driver import pssr_pkg::*;
#(
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [TEMP_W-1:0]    temperature,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        relay_drive,
    output logic [POWER_W-1:0]          power_percent,
    output logic                        run_permit
);

    localparam int E_W   = TEMP_W + 2;
    localparam int CUT_W = TEMP_W + 1;

    // configuration
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [TEMP_W-1:0]   sustain_bias_reg;
    logic signed [TEMP_W-1:0]   setpoint_reg;
    logic                       channel_enable_reg;
    logic                       input_enable_reg;
    logic [PERIOD_W-1:0]        period_ms_reg;
    logic [POWER_W-1:0]         min_power_reg;
    logic [QUOT_W-1:0]          quot_reg;

    // controller state
    pssr_state_t                state_reg, state_next;
    logic [TIME_WIDTH-1:0]      ms_counter_reg, ms_counter_next;
    logic [TIME_WIDTH-1:0]      on_deadline_reg, on_deadline_next;
    logic [TIME_WIDTH-1:0]      off_deadline_reg, off_deadline_next;
    logic                       permit_reg, permit_next;
    logic                       drive_reg, drive_next;

    logic signed [TEMP_W-1:0]   temp_reg;
    logic [POWER_W-1:0]         power_reg, power_next;

    logic                       out_valid_reg;
    logic                       relay_drive_reg;
    logic [POWER_W-1:0]         power_percent_reg;
    logic                       run_permit_reg;

    mul_req_t                   mul_req;
    logic                       mul_busy;
    logic signed [PROD_W-1:0]   mul_product;

    logic                       accept;
    logic                       load_power;
    logic                       do_update;
    logic signed [E_W-1:0]      err;
    logic [PROD_W-1:0]          prod_shift;
    logic                       prod_pos;
    logic [PERIOD_W-1:0]        on_time;
    logic [PERIOD_W-1:0]        off_time;
    logic [TIME_WIDTH-1:0]      now_plus_on;
    logic signed [CUT_W-1:0]    cutoff;
    logic [PERIOD_W+17-1:0]     quot_wide;

    pssr_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .busy    (mul_busy),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg           <= GAIN_RST;
            sustain_bias_reg   <= '0;
            setpoint_reg       <= SETPOINT_RST;
            channel_enable_reg <= 1'b0;
            input_enable_reg   <= 1'b0;
            period_ms_reg      <= '0;
            min_power_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN:           gain_reg           <= cfg_data[GAIN_W-1:0];
                CFG_SUSTAIN_BIAS:   sustain_bias_reg   <= cfg_data[TEMP_W-1:0];
                CFG_SETPOINT:       setpoint_reg       <= cfg_data[TEMP_W-1:0];
                CFG_CHANNEL_ENABLE: channel_enable_reg <= cfg_data[0];
                CFG_INPUT_ENABLE:   input_enable_reg   <= cfg_data[0];
                CFG_PERIOD_MS:      period_ms_reg      <= cfg_data[PERIOD_W-1:0];
                CFG_MIN_POWER:      min_power_reg      <= cfg_data[POWER_W-1:0];
                default:            ;
            endcase
        end
    end

    // period / 100, refreshed every cycle
    assign quot_wide = (PERIOD_W + 17)'(period_ms_reg) * (PERIOD_W + 17)'(DIV100_MAGIC);

    always_ff @(posedge clk)
    begin
        quot_reg <= QUOT_W'(quot_wide >> DIV100_SHIFT);
    end

    // error term and power
    always_comb
    begin
        err = E_W'(setpoint_reg) - E_W'(temperature) + E_W'(sustain_bias_reg);
        prod_shift = $unsigned(mul_product) >> TEMP_FRAC_BITS;
        prod_pos   = !mul_product[PROD_W-1] && (mul_product != '0);
        if (!channel_enable_reg || !input_enable_reg || !prod_pos)
        begin
            power_next = '0;
        end
        else if (prod_shift > PROD_W'(MAX_POWER))
        begin
            power_next = POWER_W'(MAX_POWER);
        end
        else
        begin
            power_next = prod_shift[POWER_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        accept         = 1'b0;
        load_power     = 1'b0;
        do_update      = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.mcand  = err;
        mul_req.mplier = gain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept        = 1'b1;
                    mul_req.start = 1'b1;
                    state_next    = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_POWER;
                end
            end
            ST_POWER:
            begin
                load_power     = 1'b1;
                mul_req.start  = 1'b1;
                mul_req.mcand  = MCAND_W'(quot_reg);
                mul_req.mplier = MPLIER_W'(power_next);
                state_next     = ST_MUL_TIME;
            end
            ST_MUL_TIME:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    do_update  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg <= temperature;
        end
        if (load_power)
        begin
            power_reg <= power_next;
        end
    end

    // permit and relay deadlines
    always_comb
    begin
        on_time     = mul_product[PERIOD_W-1:0];
        off_time    = period_ms_reg - on_time;
        now_plus_on = ms_counter_reg + TIME_WIDTH'(on_time);
        cutoff      = CUT_W'(setpoint_reg) + CUT_W'(sustain_bias_reg);

        permit_next       = permit_reg;
        on_deadline_next  = on_deadline_reg;
        off_deadline_next = off_deadline_reg;
        drive_next        = drive_reg;
        ms_counter_next   = ms_counter_reg + 1'b1;

        if (!channel_enable_reg || !input_enable_reg)
        begin
            permit_next = 1'b0;
        end
        if (input_enable_reg && (power_reg >= min_power_reg))
        begin
            permit_next      = 1'b1;
            on_deadline_next = now_plus_on;
        end
        if (permit_next && (CUT_W'(temp_reg) >= cutoff))
        begin
            permit_next = 1'b0;
        end

        if (permit_next)
        begin
            if (!drive_reg && (ms_counter_reg > off_deadline_reg))
            begin
                drive_next        = 1'b1;
                off_deadline_next = ms_counter_reg + TIME_WIDTH'(off_time);
            end
            else if (drive_reg && (ms_counter_reg > on_deadline_next))
            begin
                drive_next       = 1'b0;
                on_deadline_next = now_plus_on;
            end
        end
        else
        begin
            drive_next        = 1'b0;
            on_deadline_next  = '0;
            off_deadline_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_counter_reg   <= '0;
            on_deadline_reg  <= '0;
            off_deadline_reg <= '0;
            permit_reg       <= 1'b0;
            drive_reg        <= 1'b0;
        end
        else if (do_update)
        begin
            ms_counter_reg   <= ms_counter_next;
            on_deadline_reg  <= on_deadline_next;
            off_deadline_reg <= off_deadline_next;
            permit_reg       <= permit_next;
            drive_reg        <= drive_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            relay_drive_reg   <= drive_next;
            power_percent_reg <= power_reg;
            run_permit_reg    <= permit_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_drive   = relay_drive_reg;
    assign power_percent = power_percent_reg;
    assign run_permit    = run_permit_reg;

endmodule

// File: bench/ssr_checker.sv
`timescale 1ns / 1ps

module ssr_checker import pssr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [TEMP_W-1:0]    temperature,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        relay_drive,
    input  logic [POWER_W-1:0]          power_percent,
    input  logic                        run_permit,
    output int                          fail_count,
    output int                          outstanding,
    output int                          beats_checked,
    output int                          drive_on_beats,
    output int                          permit_beats
);

    localparam int TICK_W = TIME_WIDTH_DEF;

    typedef struct packed {
        logic                   relay;
        logic [POWER_W-1:0]     power;
        logic                   permit;
    } ssr_result_t;

    logic [GAIN_W-1:0]          gain_r;
    logic signed [TEMP_W-1:0]   bias_r;
    logic signed [TEMP_W-1:0]   setpoint_r;
    logic                       chan_en_r;
    logic                       in_en_r;
    logic [PERIOD_W-1:0]        period_r;
    logic [POWER_W-1:0]         min_power_r;

    logic [TICK_W-1:0]          tick_now;
    logic [TICK_W-1:0]          on_deadline;
    logic [TICK_W-1:0]          off_deadline;
    logic                       permit_r;
    logic                       drive_r;

    ssr_result_t                relay_results_q[$];
    int                         mismatches;
    int                         checked;
    int                         drive_on;
    int                         permit_on;

    function automatic logic [POWER_W-1:0] power_for(logic signed [TEMP_W-1:0] t);
        longint x;
        if (!chan_en_r || !in_en_r)
            return '0;
        x = (longint'(setpoint_r) - longint'(t) + longint'(bias_r)) * longint'(gain_r);
        if (x <= 0)
            return '0;
        x = x >>> TEMP_FRAC_BITS_DEF;
        return (x > MAX_POWER) ? POWER_W'(MAX_POWER) : POWER_W'(x);
    endfunction

    // one millisecond tick of the controller
    function automatic ssr_result_t advance_tick(logic signed [TEMP_W-1:0] t);
        logic [POWER_W-1:0] pwr;
        logic [TICK_W-1:0]  on_time;
        logic [TICK_W-1:0]  off_time;
        ssr_result_t        r;
        pwr      = power_for(t);
        on_time  = (TICK_W'(period_r) / 100) * TICK_W'(pwr);
        off_time = TICK_W'(period_r) - on_time;

        if (!chan_en_r || !in_en_r)
            permit_r = 1'b0;
        if (in_en_r && pwr >= min_power_r)
        begin
            permit_r    = 1'b1;
            on_deadline = tick_now + on_time;
        end
        if (permit_r && (int'(t) >= int'(setpoint_r) + int'(bias_r)))
            permit_r = 1'b0;

        if (permit_r)
        begin
            if (!drive_r && tick_now > off_deadline)
            begin
                drive_r      = 1'b1;
                off_deadline = tick_now + off_time;
            end
            else if (drive_r && tick_now > on_deadline)
            begin
                drive_r     = 1'b0;
                on_deadline = tick_now + on_time;
            end
        end
        else
        begin
            drive_r      = 1'b0;
            on_deadline  = '0;
            off_deadline = '0;
        end

        tick_now = tick_now + 1'b1;
        r.relay  = drive_r;
        r.power  = pwr;
        r.permit = permit_r;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssr_result_t want;
        ssr_result_t got;
        if (!rst_n)
        begin
            gain_r       = GAIN_RST;
            bias_r       = '0;
            setpoint_r   = SETPOINT_RST;
            chan_en_r    = 1'b0;
            in_en_r      = 1'b0;
            period_r     = '0;
            min_power_r  = '0;
            tick_now     = '0;
            on_deadline  = '0;
            off_deadline = '0;
            permit_r     = 1'b0;
            drive_r      = 1'b0;
            relay_results_q.delete();
            mismatches   = 0;
            checked      = 0;
            drive_on     = 0;
            permit_on    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GAIN:           gain_r      = cfg_data[GAIN_W-1:0];
                    CFG_SUSTAIN_BIAS:   bias_r      = cfg_data;
                    CFG_SETPOINT:       setpoint_r  = cfg_data;
                    CFG_CHANNEL_ENABLE: chan_en_r   = cfg_data[0];
                    CFG_INPUT_ENABLE:   in_en_r     = cfg_data[0];
                    CFG_PERIOD_MS:      period_r    = cfg_data[PERIOD_W-1:0];
                    CFG_MIN_POWER:      min_power_r = cfg_data[POWER_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got.relay  = relay_drive;
                got.power  = power_percent;
                got.permit = run_permit;
                if (relay_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: relay=%0d power=%0d permit=%0d",
                                 got.relay, got.power, got.permit);
                end
                else
                begin
                    want = relay_results_q.pop_front();
                    if (got.relay !== want.relay || got.power !== want.power ||
                        got.permit !== want.permit)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at beat %0d: expected relay=%0d power=%0d permit=%0d, got relay=%0d power=%0d permit=%0d",
                                     checked, want.relay, want.power, want.permit,
                                     got.relay, got.power, got.permit);
                    end
                    checked++;
                    if (want.relay)
                        drive_on++;
                    if (want.permit)
                        permit_on++;
                end
            end

            if (in_valid && in_ready)
                relay_results_q.push_back(advance_tick(temperature));
        end
        fail_count     <= mismatches;
        outstanding    <= relay_results_q.size();
        beats_checked  <= checked;
        drive_on_beats <= drive_on;
        permit_beats   <= permit_on;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pssr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int RANDOM_TICKS_PER_PHASE = 190;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [TEMP_W-1:0]   temperature;
    logic                       out_valid;
    logic                       out_ready;
    logic                       relay_drive;
    logic [POWER_W-1:0]         power_percent;
    logic                       run_permit;

    int fail_count;
    int outstanding;
    int beats_checked;
    int drive_on_beats;
    int permit_beats;

    int send_idle_pct;
    int recv_stall_pct;
    int ticks_sent;
    int settings_used;
    int cur_gain;
    int cur_setpoint;
    int cur_bias;

    proportional_ssr_time_driver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .temperature   (temperature),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .relay_drive   (relay_drive),
        .power_percent (power_percent),
        .run_permit    (run_permit)
    );

    ssr_checker u_ssr_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .temperature    (temperature),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .relay_drive    (relay_drive),
        .power_percent  (power_percent),
        .run_permit     (run_permit),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .beats_checked  (beats_checked),
        .drive_on_beats (drive_on_beats),
        .permit_beats   (permit_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic int sat_temp(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // mostly temperatures that sweep power across 0..100 and the cut-off
    function automatic int pick_temp();
        int cut;
        int span;
        cut  = cur_setpoint + cur_bias;
        span = (cur_gain == 0) ? 200 : 1800 / cur_gain + 2;
        case ($urandom_range(9))
            0:       return $signed(TEMP_W'($urandom));
            1, 2:    return sat_temp(cut + int'($urandom_range(0, 40)) - 20);
            default: return sat_temp(cut - int'($urandom_range(0, span)));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input int g, input int bias, input int sp, input int ch,
                                 input int ie, input int period, input int minp);
        write_reg(CFG_GAIN,           CFG_DATA_W'(g));
        write_reg(CFG_SUSTAIN_BIAS,   CFG_DATA_W'(bias));
        write_reg(CFG_SETPOINT,       CFG_DATA_W'(sp));
        write_reg(CFG_CHANNEL_ENABLE, CFG_DATA_W'(ch));
        write_reg(CFG_INPUT_ENABLE,   CFG_DATA_W'(ie));
        write_reg(CFG_PERIOD_MS,      CFG_DATA_W'(period));
        write_reg(CFG_MIN_POWER,      CFG_DATA_W'(minp));
        cfg_we       <= 1'b0;
        cur_gain     = g;
        cur_bias     = bias;
        cur_setpoint = sp;
        settings_used++;
    endtask

    task automatic random_settings();
        int g;
        int bias;
        int sp;
        int period;
        int minp;
        case ($urandom_range(5))
            0:       g = 255;
            1:       g = $urandom_range(0, 4);
            default: g = $urandom_range(0, 255);
        endcase
        if ($urandom_range(7) == 0)
            sp = $signed(TEMP_W'($urandom));
        else
            sp = int'($urandom_range(0, 4000)) - 1000;
        if ($urandom_range(7) == 0)
            bias = $signed(TEMP_W'($urandom));
        else
            bias = int'($urandom_range(0, 200)) - 100;
        case ($urandom_range(9))
            0:       period = 0;
            1:       period = 65535;
            2:       period = $urandom_range(0, 65535);
            3, 4:    period = $urandom_range(100, 400);
            default: period = $urandom_range(1, 120);
        endcase
        if ($urandom_range(9) == 0)
            minp = $urandom_range(101, 127);
        else
            minp = $urandom_range(0, 100);
        load_settings(g, bias, sp, $urandom_range(9) != 0, $urandom_range(9) != 0,
                      period, minp);
    endtask

    task automatic send_temp(input int t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        temperature <= TEMP_W'(t);
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int phase;
        int phase_end;
        int seg;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        temperature    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ticks_sent     = 0;
        settings_used  = 0;
        cur_gain       = 1;
        cur_setpoint   = 80;
        cur_bias       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, both channels off
        send_temp(0);
        send_temp(32767);
        wait_idle();

        load_settings(255, 0, 32767, 1, 1, 65535, 0);
        send_temp(-32768);
        send_temp(0);
        send_temp(32767);
        wait_idle();

        // zero gain with a period shorter than 100
        load_settings(0, 0, 0, 1, 1, 7, 0);
        send_temp(-1);
        send_temp(-32768);
        wait_idle();

        load_settings(16, -32768, -32768, 1, 1, 100, 50);
        send_temp(-32768);
        wait_idle();

        // cut-off out of reach, full power, relay cycling
        load_settings(255, 32767, 32767, 1, 1, 100, 50);
        send_temp(-32768);
        send_temp(32767);
        send_temp(0);
        send_temp(5);
        wait_idle();

        // channel off, input on
        load_settings(8, 0, 0, 0, 1, 300, 0);
        send_temp(-100);
        send_temp(-200);
        wait_idle();
        load_settings(8, 0, 0, 0, 1, 300, 1);
        send_temp(-100);
        wait_idle();

        // minimum power above full scale
        load_settings(255, 0, 1000, 1, 1, 50, 127);
        send_temp(0);
        send_temp(-5000);
        wait_idle();

        load_settings(255, 0, 1000, 1, 0, 50, 0);
        send_temp(0);
        wait_idle();

        // hysteresis around the cut-off
        load_settings(16, 16, 160, 1, 1, 20, 30);
        send_temp(0);
        send_temp(170);
        send_temp(176);
        send_temp(175);
        wait_idle();
        write_reg(CFG_UNUSED, '1);
        cfg_we <= 1'b0;
        send_temp(100);
        wait_idle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 84;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct <= 36;
                end
            endcase
            phase_end = ticks_sent + RANDOM_TICKS_PER_PHASE;
            while (ticks_sent < phase_end)
            begin
                random_settings();
                seg = $urandom_range(10, 60);
                repeat (seg) send_temp(pick_temp());
                wait_idle();
            end
        end

        repeat (40) @(posedge clk);
        $display("covered %0d temperature ticks over %0d register settings",
                 ticks_sent, settings_used);
        $display("in four handshake mixes, %0d results checked, relay on in %0d, permit in %0d",
                 beats_checked, drive_on_beats, permit_beats);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hdl/pssr_pkg.sv
hdl/pssr_serial_mul.sv
hdl/proportional_ssr_time_driver.sv
bench/ssr_checker.sv
bench/tb_top.sv
